/* design/lsrs_pkg.sv */
// Shared types, widths and reset values for the line sensor readout sequencer.
package lsrs_pkg;

	localparam int TIME_W     = 32;
	localparam int TICK_W     = 10;
	localparam int DLY_W      = 15;
	localparam int SAMP_W     = 10;
	localparam int IDX_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int PIXELS_DEF = 128;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_TICK_MICROS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MICROS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_MICROS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_MICROS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE   = 3'd4;

	localparam logic [TICK_W-1:0] TICK_RST  = 10'd10;
	localparam logic [DLY_W-1:0]  START_RST = 15'd25;
	localparam logic [DLY_W-1:0]  HALF_RST  = 15'd50;
	localparam logic [DLY_W-1:0]  GAP_RST   = 15'd500;

	typedef struct packed {
		logic [SAMP_W-1:0] sample_a;
		logic [SAMP_W-1:0] sample_b;
		logic              start_request;
	} in_item_t;

	typedef struct packed {
		logic              start_level;
		logic              clock_level;
		logic              sample_valid;
		logic [IDX_W-1:0]  pixel_index;
		logic [SAMP_W-1:0] pixel_a;
		logic [SAMP_W-1:0] pixel_b;
		logic              frame_done;
	} out_item_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_micros;
		logic [DLY_W-1:0]  start_pulse_micros;
		logic [DLY_W-1:0]  clock_half_micros;
		logic [DLY_W-1:0]  frame_gap_micros;
		logic              run_enable;
	} cfg_t;

endpackage

/* design/lsrs_front.sv */
// Front end: accepts tick transactions into a two-entry queue.
module lsrs_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  lsrs_pkg::in_item_t in_data,
	output logic             q_valid,
	input  logic             q_stall,
	output lsrs_pkg::in_item_t q_data
);
	import lsrs_pkg::*;

	in_item_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_stall = (count_q == 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_data   = mem_q[rd_ptr_q];
	assign push     = in_valid && !in_stall;
	assign pop      = q_valid && !q_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_data;
	end

endmodule

/* design/lsrs_core.sv */
// Back end: sequencer state, one tick per cycle unless stalled, registered result slot.
module lsrs_core #(
	parameter int PIXELS = lsrs_pkg::PIXELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lsrs_pkg::cfg_t     cfg,
	input  logic               q_valid,
	output logic               q_stall,
	input  lsrs_pkg::in_item_t q_data,
	output logic               out_valid,
	input  logic               out_stall,
	output lsrs_pkg::out_item_t out_data
);
	import lsrs_pkg::*;

	localparam int CNT_W = $clog2(PIXELS + 2);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(PIXELS + 1);

	typedef enum logic [2:0] {
		PH_GAP  = 3'b001,
		PH_PEND = 3'b010,
		PH_CLK  = 3'b100
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [TIME_W-1:0]  micros_q, micros_d;
	logic               chigh_q, chigh_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [TIME_W-1:0]  sst_q, sst_d;
	logic [TIME_W-1:0]  rise_q, rise_d;
	logic [TIME_W-1:0]  fall_q, fall_d;
	logic [TIME_W-1:0]  gap_q, gap_d;
	logic               spin_q, spin_d;
	logic               cpin_q, cpin_d;
	logic [CNT_W+IDX_W-1:0] cnt_ext;
	out_item_t          res;
	out_item_t          out_data_q;
	logic               out_valid_q;
	logic               take;

	assign q_stall   = out_valid_q && out_stall;
	assign take      = q_valid && !q_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		micros_d = micros_q + TIME_W'(cfg.tick_micros);
		phase_d  = phase_q;
		chigh_d  = chigh_q;
		cnt_d    = cnt_q;
		sst_d    = sst_q;
		rise_d   = rise_q;
		fall_d   = fall_q;
		gap_d    = gap_q;
		spin_d   = spin_q;
		cpin_d   = cpin_q;
		cnt_ext  = {{IDX_W{1'b0}}, cnt_q};
		res      = '0;

		// a request rearms only while waiting out the gap
		if (q_data.start_request && phase_d == PH_GAP) phase_d = PH_PEND;

		if (cfg.run_enable) begin
			if (phase_d == PH_PEND) begin
				spin_d  = 1'b1;
				sst_d   = micros_d;
				phase_d = PH_CLK;
			end
			if (phase_d == PH_CLK) begin
				if (micros_d - sst_d >= TIME_W'(cfg.start_pulse_micros)) spin_d = 1'b0;
				if (cnt_d < LAST) begin
					if (chigh_d) begin
						cpin_d = 1'b1;
						if (micros_d - rise_d >= TIME_W'(cfg.clock_half_micros)) begin
							res.sample_valid = 1'b1;
							res.pixel_index  = cnt_ext[IDX_W-1:0];
							res.pixel_a      = q_data.sample_a;
							res.pixel_b      = q_data.sample_b;
							chigh_d          = 1'b0;
							fall_d           = micros_d;
						end
					end
					if (!chigh_d) begin
						cpin_d = 1'b0;
						if (micros_d - fall_d >= TIME_W'(cfg.clock_half_micros)) begin
							rise_d  = micros_d;
							cnt_d   = cnt_d + CNT_W'(1);
							chigh_d = 1'b1;
						end
					end
				end
				if (cnt_d >= LAST) begin
					cpin_d         = 1'b0;
					gap_d          = micros_d;
					phase_d        = PH_GAP;
					res.frame_done = 1'b1;
				end
			end
			if (phase_d == PH_GAP) begin
				spin_d = 1'b0;
				if (micros_d - gap_d >= TIME_W'(cfg.frame_gap_micros)) begin
					cnt_d    = '0;
					phase_d  = PH_PEND;
					micros_d = '0;
				end
			end
		end

		res.start_level = spin_d;
		res.clock_level = cpin_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PEND;
			micros_q    <= '0;
			chigh_q     <= 1'b1;
			cnt_q       <= '0;
			sst_q       <= '0;
			rise_q      <= '0;
			fall_q      <= '0;
			gap_q       <= '0;
			spin_q      <= 1'b0;
			cpin_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q  <= phase_d;
				micros_q <= micros_d;
				chigh_q  <= chigh_d;
				cnt_q    <= cnt_d;
				sst_q    <= sst_d;
				rise_q   <= rise_d;
				fall_q   <= fall_d;
				gap_q    <= gap_d;
				spin_q   <= spin_d;
				cpin_q   <= cpin_d;
			end
			if (take) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_data_q <= res;
	end

endmodule

/* design/line_sensor_readout_sequencer.sv */
// A tick transaction's result reaches out_data through a queue entry in lsrs_front
// and then the result register in lsrs_core; it is taken when out_stall is low.
// Throughput: one tick per cycle while out_stall is low; the lsrs_core step is combinational.
// A two-entry queue in lsrs_front takes input while the result register waits on out_stall.
// Reset (arst_n low, asynchronous): registers back to defaults, time zero,
// start pending, queue and result slot empty.
module line_sensor_readout_sequencer #(
	parameter int PIXELS = lsrs_pkg::PIXELS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  lsrs_pkg::in_item_t                     in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output lsrs_pkg::out_item_t                    out_data,
	input  logic                                   cfg_we,
	input  logic [lsrs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lsrs_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import lsrs_pkg::*;

	cfg_t     cfg_q;
	logic     q_valid;
	logic     q_stall;
	in_item_t q_data;

	// Config register file; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_micros        <= TICK_RST;
			cfg_q.start_pulse_micros <= START_RST;
			cfg_q.clock_half_micros  <= HALF_RST;
			cfg_q.frame_gap_micros   <= GAP_RST;
			cfg_q.run_enable         <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICK_MICROS:  cfg_q.tick_micros        <= cfg_data[TICK_W-1:0];
				REG_START_MICROS: cfg_q.start_pulse_micros <= cfg_data[DLY_W-1:0];
				REG_HALF_MICROS:  cfg_q.clock_half_micros  <= cfg_data[DLY_W-1:0];
				REG_GAP_MICROS:   cfg_q.frame_gap_micros   <= cfg_data[DLY_W-1:0];
				REG_RUN_ENABLE:   cfg_q.run_enable         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Front: buffers tick transactions; the input stalls only once both entries are full.
	lsrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_stall  (q_stall),
		.q_data   (q_data)
	);

	// Back: time counter, start pulse, pixel clock and sampling.
	lsrs_core #(
		.PIXELS (PIXELS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_stall   (q_stall),
		.q_data    (q_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Pixel fields are zero unless a pair was sampled.
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.sample_valid |->
			out_data.pixel_index == '0 && out_data.pixel_a == '0 && out_data.pixel_b == '0)
		else $error("pixel fields set without a sample");

	// Sampling ends the high phase, so the clock pin is low afterward.
	a_sample_clock_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sample_valid |-> !out_data.clock_level)
		else $error("clock high on a sampling tick");

	// End of frame parks the pixel clock low.
	a_done_clock_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_done |-> !out_data.clock_level)
		else $error("clock high at frame end");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the line sensor readout sequencer.
`timescale 1ns / 1ps

module tb_top;
	import lsrs_pkg::*;

	localparam int PULSES       = PIXELS_DEF + 1;  // dummy pixel plus the real ones
	localparam int TICK_TARGET  = 1250;
	localparam int LONG_HOLD    = 200;             // cycles of receiver hold-off
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 6;               // idle cycles after the last result arrives

	typedef enum logic [2:0] {
		SEQ_GAP      = 3'b001,
		SEQ_START    = 3'b010,
		SEQ_CLOCKING = 3'b100
	} seq_phase_t;

	// Predicts pin levels and samples per tick, holds them until the block
	// delivers its results, and compares field by field.
	class readout_scoreboard;
		cfg_t        regs;
		bit [31:0]   now_us, start_us, rise_us, fall_us, gap_us;
		seq_phase_t  phase;
		bit          clk_high, start_pin, clock_pin;
		bit [7:0]    pulses;
		out_item_t   tick_results_due[$];
		int          errors, checked, samples, frames;

		function new();
			regs.tick_micros        = TICK_RST;
			regs.start_pulse_micros = START_RST;
			regs.clock_half_micros  = HALF_RST;
			regs.frame_gap_micros   = GAP_RST;
			regs.run_enable         = 1'b1;
			now_us    = '0;
			start_us  = '0;
			rise_us   = '0;
			fall_us   = '0;
			gap_us    = '0;
			phase     = SEQ_START;
			clk_high  = 1'b1;
			start_pin = 1'b0;
			clock_pin = 1'b0;
			pulses    = '0;
			errors    = 0;
			checked   = 0;
			samples   = 0;
			frames    = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TICK_MICROS:  regs.tick_micros        = data[TICK_W-1:0];
				REG_START_MICROS: regs.start_pulse_micros = data[DLY_W-1:0];
				REG_HALF_MICROS:  regs.clock_half_micros  = data[DLY_W-1:0];
				REG_GAP_MICROS:   regs.frame_gap_micros   = data[DLY_W-1:0];
				REG_RUN_ENABLE:   regs.run_enable         = data[0];
				default: ;
			endcase
		endfunction

		function out_item_t advance_tick(in_item_t t);
			out_item_t r;
			r = '0;
			now_us += 32'(regs.tick_micros);
			// a start request only rearms from the gap wait, even with the run disabled
			if (t.start_request && phase == SEQ_GAP)
				phase = SEQ_START;
			if (regs.run_enable) begin
				if (phase == SEQ_START) begin
					start_pin = 1'b1;
					start_us  = now_us;
					phase     = SEQ_CLOCKING;
				end
				if (phase == SEQ_CLOCKING) begin
					if (now_us - start_us >= 32'(regs.start_pulse_micros))
						start_pin = 1'b0;
					if (pulses < PULSES) begin
						if (clk_high) begin
							clock_pin = 1'b1;
							// stale stamps wrap, so the first high phase may end at once
							if (now_us - rise_us >= 32'(regs.clock_half_micros)) begin
								r.sample_valid = 1'b1;
								r.pixel_index  = pulses;
								r.pixel_a      = t.sample_a;
								r.pixel_b      = t.sample_b;
								clk_high       = 1'b0;
								fall_us        = now_us;
							end
						end
						if (!clk_high) begin
							clock_pin = 1'b0;
							if (now_us - fall_us >= 32'(regs.clock_half_micros)) begin
								rise_us  = now_us;
								pulses   = pulses + 8'd1;
								clk_high = 1'b1;
							end
						end
					end
					if (pulses >= PULSES) begin
						clock_pin    = 1'b0;
						gap_us       = now_us;
						phase        = SEQ_GAP;
						r.frame_done = 1'b1;
					end
				end
				if (phase == SEQ_GAP) begin
					start_pin = 1'b0;
					// zero gap rearms the next frame on the same tick
					if (now_us - gap_us >= 32'(regs.frame_gap_micros)) begin
						pulses = '0;
						phase  = SEQ_START;
						now_us = '0;
					end
				end
			end
			r.start_level = start_pin;
			r.clock_level = clock_pin;
			samples += r.sample_valid;
			frames  += r.frame_done;
			return r;
		endfunction

		function void note_tick(in_item_t t);
			tick_results_due.push_back(advance_tick(t));
		endfunction

		function int pending();
			return tick_results_due.size();
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got %0h, expected %0h", checked, name, got, want));
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (tick_results_due.size() == 0) begin
				report($sformatf("result with nothing expected: %p", got));
				return;
			end
			want = tick_results_due.pop_front();
			checked++;
			compare_field("start_level", 32'(got.start_level), 32'(want.start_level));
			compare_field("clock_level", 32'(got.clock_level), 32'(want.clock_level));
			compare_field("sample_valid", 32'(got.sample_valid), 32'(want.sample_valid));
			compare_field("pixel_index", 32'(got.pixel_index), 32'(want.pixel_index));
			compare_field("pixel_a", 32'(got.pixel_a), 32'(want.pixel_a));
			compare_field("pixel_b", 32'(got.pixel_b), 32'(want.pixel_b));
			compare_field("frame_done", 32'(got.frame_done), 32'(want.frame_done));
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	readout_scoreboard sb = new();

	int  cycles        = 0;
	int  ticks_sent    = 0;
	int  settings_used = 1;     // reset values count as the first setting
	int  burst_left    = 0;
	logic hold_go      = 1'b0;  // main flow asks the receiver for one long hold-off

	line_sensor_readout_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Run limit: a hang anywhere ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles, sb.pending());
			$display("line_sensor_readout_sequencer regression: fail");
			$finish;
		end
	end

	// Monitor: note accepted ticks first, then check delivered results.
	// Both sample pre-edge values, so the order within the step does not matter.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_tick(in_data);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// Receiver: switches among stall patterns each time mode_left runs out, and
	// on request holds off through the LONG_HOLD hold-off so the front queue fills
	// and the block stalls its input.
	int       hold_left = 0;
	int       mode_left = 0;
	int       stall_mode = 0;
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_go) begin
			hold_go   <= 1'b0;
			hold_left <= LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 120);
			end else begin
				mode_left = mode_left - 1;
			end
			case (stall_mode)
				0:       out_stall <= 1'b0;                          // free flowing
				1:       out_stall <= 1'($urandom_range(0, 1));      // coin toss
				2:       out_stall <= (cycles % 3 == 0);             // periodic
				default: out_stall <= ($urandom_range(0, 3) != 0);  // mostly stalled
			endcase
		end
	end

	function automatic in_item_t make_item(int a, int b, bit req);
		in_item_t t;
		t.sample_a      = a[SAMP_W-1:0];
		t.sample_b      = b[SAMP_W-1:0];
		t.start_request = req;
		return t;
	endfunction

	function automatic in_item_t random_item();
		int a, b;
		a = $urandom_range(0, 1023);
		b = $urandom_range(0, 1023);
		if ($urandom_range(0, 15) == 0)
			a = ($urandom_range(0, 1) != 0) ? 1023 : 0;
		if ($urandom_range(0, 15) == 0)
			b = ($urandom_range(0, 1) != 0) ? 1023 : 0;
		return make_item(a, b, $urandom_range(0, 3) == 0);
	endfunction

	// Offer one tick and hold it until the transaction completes.
	task automatic send_tick(in_item_t t);
		in_data  <= t;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		ticks_sent++;
	endtask

	// Wait until every expected result has arrived, then let the pipe settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Program all registers; unused upper data bits of the narrow ones get noise.
	task automatic program_regs(int tick, int start, int half, int gap, bit run);
		logic [CFG_DATA_W-1:0] noise;
		noise = CFG_DATA_W'($urandom);
		cfg_write(REG_TICK_MICROS, {noise[CFG_DATA_W-1:TICK_W], tick[TICK_W-1:0]});
		cfg_write(REG_START_MICROS, start[DLY_W-1:0]);
		cfg_write(REG_HALF_MICROS, half[DLY_W-1:0]);
		cfg_write(REG_GAP_MICROS, gap[DLY_W-1:0]);
		cfg_write(REG_RUN_ENABLE, {noise[CFG_DATA_W-1:1], run});
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Random ticks in bursts with random gaps; optionally one long receiver hold.
	task automatic run_phase(int n_items, bit sender_idles, bit with_hold);
		int gap_len;
		for (int i = 0; i < n_items; i++) begin
			if (sender_idles && burst_left == 0) begin
				burst_left = $urandom_range(1, 50);
				gap_len    = $urandom_range(0, 8);
				if (gap_len > 0) begin
					in_valid <= 1'b0;
					repeat (gap_len) @(posedge clk);
				end
			end
			if (with_hold && i == n_items / 4)
				hold_go <= 1'b1;
			send_tick(random_item());
			if (burst_left > 0)
				burst_left--;
		end
		wait_idle();
	endtask

	function automatic int clamp_delay(int v);
		return (v > 32767) ? 32767 : v;
	endfunction

	initial begin
		int tick, half;
		bit first_random;
		int ab_edge[4] = '{0, 1023, 'h2AA, 'h155};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks at reset settings: sample extremes and alternating bit
		// patterns, start request toggling; covers start pulse rise/fall and the
		// first dummy sample.
		for (int i = 0; i < 16; i++)
			send_tick(make_item(ab_edge[i % 4], 1023 - ab_edge[i % 4], i[1]));
		wait_idle();

		// Writes to indexes past the last register must change nothing.
		for (int r = REG_RUN_ENABLE + 1; r < (1 << CFG_IDX_W); r++)
			cfg_write(r[CFG_IDX_W-1:0], '1);
		cfg_we <= 1'b0;

		// Zero delays at a tick of 1000: one pulse per tick, frames back to back.
		program_regs(1000, 0, 0, 0, 1'b1);
		run_phase(300, 1'b1, 1'b0);

		// A tick of 1 with the longest delays: the pins barely move.
		program_regs(1, 32767, 32767, 32767, 1'b1);
		run_phase(40, 1'b1, 1'b0);

		// Run disabled: only time advances, start requests may still rearm.
		program_regs(500, 100, 200, 30000, 1'b0);
		run_phase(40, 1'b0, 1'b0);

		// Random settings; the first random phase also carries the long hold-off.
		first_random = 1'b1;
		while (ticks_sent < TICK_TARGET) begin
			case ($urandom_range(0, 3))
				0:       tick = 1000;
				1:       tick = $urandom_range(1, 20);
				default: tick = $urandom_range(1, 1000);
			endcase
			case ($urandom_range(0, 3))
				0, 1:    half = 0;
				2:       half = $urandom_range(0, tick);
				default: half = clamp_delay($urandom_range(0, tick * 3));
			endcase
			program_regs(tick, clamp_delay($urandom_range(0, tick * 4)), half,
			             clamp_delay($urandom_range(0, tick * 30)),
			             $urandom_range(0, 5) != 0);
			run_phase($urandom_range(60, 120), first_random || ($urandom_range(0, 3) != 0),
			          first_random);
			first_random = 1'b0;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() > 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));

		$display("run covered %0d ticks over %0d register settings", ticks_sent, settings_used);
		$display("%0d pixel samples, %0d completed frames, %0d results checked, %0d mismatches",
		         sb.samples, sb.frames, sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("line_sensor_readout_sequencer regression: pass");
		else
			$display("line_sensor_readout_sequencer regression: fail");
		$finish;
	end

endmodule
